/* hdl/hfvr_pkg.sv */
// shared types and constants for the host failover vote ranker
// used by hfvr_ctrl, hfvr_datapath and host_failover_vote_ranker_unit
`timescale 1ns / 1ps
`default_nettype none

package hfvr_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SELECT = 2'd1,
        OP_REPORT = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // report outcome codes, every other code is an ignored error
    localparam logic [1:0] OC_SUCCESS   = 2'd0;
    localparam logic [1:0] OC_CONN_FAIL = 2'd1;

    // scheme flag masks
    localparam logic [1:0] MASK_HTTP  = 2'b01;
    localparam logic [1:0] MASK_HTTPS = 2'b10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RPT,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_WALK_END,
        ST_RD,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_POS,
        RD_NEXT,
        RD_NEXT2,
        RD_FINAL
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_INC,
        WR_STEP,
        WR_CUR
    } t_wr_sel;

    typedef struct packed {
        logic    capture;
        logic    set_session;
        t_rd_sel rd;
        t_wr_sel wr;
        logic    load_cur;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic oc_success;
        logic oc_fail;
        logic report_ok;
        logic next_ok;
        logic next2_ok;
        logic next_match;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hdl/hfvr_ctrl.sv */
// controller state machine of the vote ranker
// depends on hfvr_pkg, drives hfvr_datapath through t_cmd
`timescale 1ns / 1ps
`default_nettype none

module hfvr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_free,
    input  wire hfvr_pkg::t_dp_sts i_dp_sts,
    output hfvr_pkg::t_cmd        o_cmd,
    output logic                  o_in_ready
);

    hfvr_pkg::t_state r_state;
    hfvr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfvr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state             = r_state;
        o_in_ready          = 1'b0;
        o_cmd.capture       = 1'b0;
        o_cmd.set_session   = 1'b0;
        o_cmd.rd            = hfvr_pkg::RD_NONE;
        o_cmd.wr            = hfvr_pkg::WR_NONE;
        o_cmd.load_cur      = 1'b0;
        o_cmd.out_load      = 1'b0;
        unique case (r_state)
            hfvr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = hfvr_pkg::ST_EXEC;
                end
            end
            hfvr_pkg::ST_EXEC: begin
                n_state = hfvr_pkg::ST_RD;
                unique case (i_dp_sts.op)
                    hfvr_pkg::OP_LOAD: begin
                        o_cmd.wr = hfvr_pkg::WR_LOAD;
                    end
                    hfvr_pkg::OP_SELECT: begin
                        o_cmd.set_session = 1'b1;
                    end
                    hfvr_pkg::OP_REPORT: begin
                        if (i_dp_sts.report_ok &&
                            (i_dp_sts.oc_success || i_dp_sts.oc_fail)) begin
                            o_cmd.rd = hfvr_pkg::RD_POS;
                            n_state  = hfvr_pkg::ST_RPT;
                        end
                    end
                    hfvr_pkg::OP_NOP: begin
                        n_state = hfvr_pkg::ST_RD;
                    end
                    default: begin
                        n_state = hfvr_pkg::ST_RD;
                    end
                endcase
            end
            hfvr_pkg::ST_RPT: begin
                if (i_dp_sts.oc_success) begin
                    o_cmd.wr = hfvr_pkg::WR_INC;
                    n_state  = hfvr_pkg::ST_RD;
                end else begin
                    o_cmd.load_cur = 1'b1;
                    n_state        = hfvr_pkg::ST_WALK_RD;
                end
            end
            hfvr_pkg::ST_WALK_RD: begin
                if (i_dp_sts.next_ok) begin
                    o_cmd.rd = hfvr_pkg::RD_NEXT;
                    n_state  = hfvr_pkg::ST_WALK_CMP;
                end else begin
                    o_cmd.wr = hfvr_pkg::WR_CUR;
                    n_state  = hfvr_pkg::ST_RD;
                end
            end
            hfvr_pkg::ST_WALK_CMP: begin
                if (i_dp_sts.next_match) begin
                    o_cmd.wr = hfvr_pkg::WR_STEP;
                    if (i_dp_sts.next2_ok) begin
                        // prefetch the slot after next while this step retires
                        o_cmd.rd = hfvr_pkg::RD_NEXT2;
                    end else begin
                        n_state = hfvr_pkg::ST_WALK_END;
                    end
                end else begin
                    o_cmd.wr = hfvr_pkg::WR_CUR;
                    n_state  = hfvr_pkg::ST_RD;
                end
            end
            hfvr_pkg::ST_WALK_END: begin
                o_cmd.wr = hfvr_pkg::WR_CUR;
                n_state  = hfvr_pkg::ST_RD;
            end
            hfvr_pkg::ST_RD: begin
                o_cmd.rd = hfvr_pkg::RD_FINAL;
                n_state  = hfvr_pkg::ST_FIN;
            end
            hfvr_pkg::ST_FIN: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = hfvr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hfvr_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_out_free)
        else $error("result loaded while output register busy");

    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_in_ready)
        else $error("ready while a transaction is in work");

    a_walk_step_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr == hfvr_pkg::WR_STEP) |->
            ($past(o_cmd.rd) == hfvr_pkg::RD_NEXT || $past(o_cmd.rd) == hfvr_pkg::RD_NEXT2))
        else $error("walk step without a fetched next slot");

endmodule

`default_nettype wire

/* hdl/hfvr_datapath.sv */
// slot memory, vote session registers and result forming of the vote ranker
// depends on hfvr_pkg, commanded by hfvr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module hfvr_datapath #(
    parameter int HOSTS     = 16,
    parameter int VOTE_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hfvr_pkg::t_cmd   i_cmd,
    input  wire logic [4:0]       i_host_count,
    input  wire logic [1:0]       i_operation,
    input  wire logic [3:0]       i_slot,
    input  wire logic [7:0]       i_host_id,
    input  wire logic [1:0]       i_host_flags,
    input  wire logic             i_want_https,
    input  wire logic [1:0]       i_outcome,
    output hfvr_pkg::t_dp_sts     o_sts,
    output logic [7:0]            o_result_host,
    output logic                  o_host_found,
    output logic [3:0]            o_current_slot,
    output logic [15:0]           o_current_votes,
    output logic                  o_session_on
);

    localparam int AW = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam int CW = $clog2(HOSTS + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam logic [VOTE_BITS-1:0] VOTE_MAX = {VOTE_BITS{1'b1}};

    // captured transaction
    hfvr_pkg::t_op  r_op;
    logic [3:0]     r_slot;
    logic [7:0]     r_host_id;
    logic [1:0]     r_flags;
    logic           r_want_https;
    logic [1:0]     r_outcome;

    // session state
    logic           r_session;
    logic [AW-1:0]  r_pos;
    logic [1:0]     r_mask;

    // entry carried along the demotion walk
    logic [7:0]            r_cur_host;
    logic [1:0]            r_cur_scheme;
    logic [VOTE_BITS-1:0]  r_cur_votes;

    // slot memory and vote valid bits
    logic [7:0]            mem_host   [HOSTS];
    logic [1:0]            mem_scheme [HOSTS];
    logic [VOTE_BITS-1:0]  mem_votes  [HOSTS];
    logic [HOSTS-1:0]      r_vote_vld;

    logic [7:0]            r_a_host;
    logic [1:0]            r_a_scheme;
    logic [VOTE_BITS-1:0]  r_a_votes;
    logic                  r_a_vld;
    logic [7:0]            r_b_host;
    logic [1:0]            r_b_scheme;

    logic [XW-1:0]         hc_x;
    logic [XW-1:0]         hosts_x;
    logic [XW-1:0]         slot_x;
    logic [CW-1:0]         eff_count;
    logic [CW:0]           pos_p1;
    logic [CW:0]           pos_p2;
    logic                  slot_in_hosts;
    logic                  slot_in_count;
    logic [VOTE_BITS-1:0]  a_votes;
    logic                  next_stays;
    logic                  a_en;
    logic [AW-1:0]         a_addr;
    logic [AW-1:0]         b_addr;
    logic                  w_en;
    logic [AW-1:0]         w_addr;
    logic [7:0]            w_host;
    logic [1:0]            w_scheme;
    logic [VOTE_BITS-1:0]  w_votes;
    logic                  found;

    // effective host count, register values beyond the list act as HOSTS
    assign hc_x      = XW'(i_host_count);
    assign hosts_x   = XW'(HOSTS);
    assign eff_count = (hc_x > hosts_x) ? CW'(hosts_x) : CW'(hc_x);
    assign pos_p1    = (CW + 1)'(r_pos) + (CW + 1)'(1);
    assign pos_p2    = (CW + 1)'(r_pos) + (CW + 1)'(2);

    assign slot_x        = XW'(r_slot);
    assign slot_in_hosts = slot_x < hosts_x;
    assign slot_in_count = slot_x < XW'(eff_count);

    // votes of a never loaded slot read as zero
    assign a_votes    = r_a_vld ? r_a_votes : '0;
    assign next_stays = a_votes >= r_cur_votes;

    always_comb begin
        o_sts.op         = r_op;
        o_sts.oc_success = r_outcome == hfvr_pkg::OC_SUCCESS;
        o_sts.oc_fail    = r_outcome == hfvr_pkg::OC_CONN_FAIL;
        o_sts.report_ok  = r_session && (CW'(r_pos) < eff_count);
        o_sts.next_ok    = pos_p1 < {1'b0, eff_count};
        o_sts.next2_ok   = pos_p2 < {1'b0, eff_count};
        o_sts.next_match = (r_a_scheme & r_mask) == r_mask;
    end

    // read port addresses
    always_comb begin
        a_en   = 1'b1;
        a_addr = r_pos;
        unique case (i_cmd.rd)
            hfvr_pkg::RD_NONE:  a_en   = 1'b0;
            hfvr_pkg::RD_POS:   a_addr = r_pos;
            hfvr_pkg::RD_NEXT:  a_addr = r_pos + AW'(1);
            hfvr_pkg::RD_NEXT2: a_addr = r_pos + AW'(2);
            hfvr_pkg::RD_FINAL: a_addr = r_pos;
            default:            a_en   = 1'b0;
        endcase
    end
    assign b_addr = AW'(r_slot);

    // write port
    always_comb begin
        w_en     = 1'b1;
        w_addr   = r_pos;
        w_host   = r_cur_host;
        w_scheme = r_cur_scheme;
        w_votes  = r_cur_votes;
        unique case (i_cmd.wr)
            hfvr_pkg::WR_NONE: begin
                w_en = 1'b0;
            end
            hfvr_pkg::WR_LOAD: begin
                w_en     = slot_in_hosts;
                w_addr   = AW'(r_slot);
                w_host   = r_host_id;
                w_scheme = r_flags;
                w_votes  = '0;
            end
            hfvr_pkg::WR_INC: begin
                w_host   = r_a_host;
                w_scheme = r_a_scheme;
                w_votes  = (a_votes == VOTE_MAX) ? a_votes : a_votes + VOTE_BITS'(1);
            end
            hfvr_pkg::WR_STEP: begin
                // next slot takes this place when its votes are at least ours
                if (next_stays) begin
                    w_host   = r_a_host;
                    w_scheme = r_a_scheme;
                    w_votes  = a_votes;
                end
            end
            hfvr_pkg::WR_CUR: begin
                w_en = 1'b1;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_host[w_addr]   <= w_host;
            mem_scheme[w_addr] <= w_scheme;
            mem_votes[w_addr]  <= w_votes;
        end
        if (a_en) begin
            r_a_host   <= mem_host[a_addr];
            r_a_scheme <= mem_scheme[a_addr];
            r_a_votes  <= mem_votes[a_addr];
            r_a_vld    <= r_vote_vld[a_addr];
        end
        if (i_cmd.rd == hfvr_pkg::RD_FINAL) begin
            r_b_host   <= mem_host[b_addr];
            r_b_scheme <= mem_scheme[b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vote_vld <= '0;
        end else if (w_en) begin
            r_vote_vld[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= hfvr_pkg::t_op'(i_operation);
            r_slot       <= i_slot;
            r_host_id    <= i_host_id;
            r_flags      <= i_host_flags;
            r_want_https <= i_want_https;
            r_outcome    <= i_outcome;
        end
        if (i_cmd.load_cur) begin
            r_cur_host   <= r_a_host;
            r_cur_scheme <= r_a_scheme;
            r_cur_votes  <= a_votes >> 2;
        end else if (i_cmd.wr == hfvr_pkg::WR_STEP && !next_stays) begin
            r_cur_host   <= r_a_host;
            r_cur_scheme <= r_a_scheme;
            r_cur_votes  <= a_votes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session <= 1'b0;
            r_pos     <= '0;
            r_mask    <= '0;
        end else begin
            if (i_cmd.set_session) begin
                r_session <= 1'b1;
                r_pos     <= '0;
                r_mask    <= r_want_https ? hfvr_pkg::MASK_HTTPS : hfvr_pkg::MASK_HTTP;
            end else if (i_cmd.wr == hfvr_pkg::WR_STEP) begin
                r_pos <= r_pos + AW'(1);
            end
        end
    end

    // result of the finished transaction
    assign found = (r_op == hfvr_pkg::OP_SELECT) && slot_in_count &&
                   ((r_b_scheme & r_mask) == r_mask);

    always_comb begin
        if (r_op == hfvr_pkg::OP_SELECT) begin
            o_result_host = found ? r_b_host : 8'd0;
        end else begin
            o_result_host = r_a_host;
        end
    end
    assign o_host_found    = found;
    assign o_current_slot  = 4'(r_pos);
    assign o_current_votes = 16'(a_votes);
    assign o_session_on    = r_session;

    a_pos_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_session |-> (r_pos == '0))
        else $error("vote position moved without a session");

    a_step_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr == hfvr_pkg::WR_STEP) |=> (r_pos == $past(r_pos) + AW'(1)))
        else $error("walk step did not advance the position");

    a_mask_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_session |-> (r_mask == hfvr_pkg::MASK_HTTP || r_mask == hfvr_pkg::MASK_HTTPS))
        else $error("session without a scheme mask");

endmodule

`default_nettype wire

/* hdl/host_failover_vote_ranker_unit.sv */
// top level of the host failover vote ranker: config register, output register
// depends on hfvr_pkg, hfvr_ctrl and hfvr_datapath
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of HOSTS host slots (id, http/https flags, saturating vote count)
// with one failover vote session. Items are handled one at a time. A load,
// select, ignored report or no-op passes from the accept through the execute,
// read and finish states; its result enters the output register as the block
// goes from finish back to idle, where the next transaction can be taken. A
// success report adds the report state. A connect-failure report adds the
// report state and the demotion walk, which reads the next slot and steps
// past the following slots with matching flags up to the first that does not
// match, before the read and finish states. The finish state waits while the
// output register is not free. The walk is set by the single write port of
// the slot memory: one compare and one write per cycle, the slot after next
// being fetched in the same cycle.
// Slot data sits in a memory with registered reads; vote counts of slots never
// loaded read as zero through per-slot valid bits, so there is no clearing
// pass after reset. A result waits in the output register while the next
// transaction is accepted and worked on; the result of that one is held back
// until the register is free. host_count may be written at any time and is
// only expected to change while the block is idle.
module host_failover_vote_ranker_unit #(
    parameter int HOSTS     = 16,
    parameter int VOTE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_host_count,
    // input transaction channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [3:0]  i_slot,
    input  wire logic [7:0]  i_host_id,
    input  wire logic [1:0]  i_host_flags,
    input  wire logic        i_want_https,
    input  wire logic [1:0]  i_outcome,
    // result transaction channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_result_host,
    output logic             o_host_found,
    output logic [3:0]       o_current_slot,
    output logic [15:0]      o_current_votes,
    output logic             o_session_on
);

    hfvr_pkg::t_cmd     cmd;
    hfvr_pkg::t_dp_sts  dp_sts;

    logic [4:0]   r_host_count;
    logic         r_out_valid;
    logic [7:0]   r_result_host;
    logic         r_host_found;
    logic [3:0]   r_current_slot;
    logic [15:0]  r_current_votes;
    logic         r_session_on;

    logic [7:0]   dp_result_host;
    logic         dp_host_found;
    logic [3:0]   dp_current_slot;
    logic [15:0]  dp_current_votes;
    logic         dp_session_on;
    logic         out_free;

    // register write is always accepted, the register is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_count <= '0;
        end else if (i_cfg_valid) begin
            r_host_count <= i_cfg_host_count;
        end
    end

    // output register frees up when empty or when its result is taken now
    assign out_free = !r_out_valid || i_out_ready;

    hfvr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_dp_sts   (dp_sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    hfvr_datapath #(
        .HOSTS     (HOSTS),
        .VOTE_BITS (VOTE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_host_count    (r_host_count),
        .i_operation     (i_operation),
        .i_slot          (i_slot),
        .i_host_id       (i_host_id),
        .i_host_flags    (i_host_flags),
        .i_want_https    (i_want_https),
        .i_outcome       (i_outcome),
        .o_sts           (dp_sts),
        .o_result_host   (dp_result_host),
        .o_host_found    (dp_host_found),
        .o_current_slot  (dp_current_slot),
        .o_current_votes (dp_current_votes),
        .o_session_on    (dp_session_on)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_result_host   <= dp_result_host;
            r_host_found    <= dp_host_found;
            r_current_slot  <= dp_current_slot;
            r_current_votes <= dp_current_votes;
            r_session_on    <= dp_session_on;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_host   = r_result_host;
    assign o_host_found    = r_host_found;
    assign o_current_slot  = r_current_slot;
    assign o_current_votes = r_current_votes;
    assign o_session_on    = r_session_on;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !cmd.out_load)
        else $error("pending result overwritten");

    a_found_only_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_host_found) |-> r_session_on)
        else $error("host found without an open session");

    a_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !cmd.out_load)
        else $error("result produced while waiting for a transaction");

endmodule

`default_nettype wire
